// File: rtl/core/sngh_pkg.sv
// Shared types, constants and hash helpers for the subword n-gram hasher.
`default_nettype none
package sngh_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [7:0]  CHAR_OPEN  = 8'h3C;
    localparam logic [7:0]  CHAR_CLOSE = 8'h3E;
    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_CODE  = 8'h80;
    localparam logic [31:0] EOS_ROW    = 32'd0;

    localparam logic [2:0] CFG_MIN_NGRAM    = 3'd0;
    localparam logic [2:0] CFG_MAX_NGRAM    = 3'd1;
    localparam logic [2:0] CFG_BUCKET_COUNT = 3'd2;
    localparam logic [2:0] CFG_WORD_COUNT   = 3'd3;

    typedef struct packed {
        logic [3:0]  min_ngram;
        logic [3:0]  max_ngram;
        logic [30:0] bucket_count;
        logic [23:0] word_count;
    } t_cfg;

    typedef struct packed {
        logic [31:0] hash;
        logic        kind;
        logic        last;
    } t_job;

    function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {{24{b[7]}}, b};
        return x * FNV_PRIME;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
               (b == 8'h0C) || (b == 8'h0D) || (b == 8'h00);
    endfunction

    localparam logic [31:0] OPEN_HASH = fnv_fold(FNV_BASIS, CHAR_OPEN);

endpackage
`default_nettype wire

// File: rtl/core/sngh_front.sv
// Front end: takes text bytes, keeps the n-gram slot ring and issues hash jobs.
`default_nettype none
module sngh_front #(
    parameter int MAX_NGRAM_LEN = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_text_byte,
    input  wire logic          i_end_of_text,
    input  wire sngh_pkg::t_cfg i_cfg,
    output logic               o_job_valid,
    output sngh_pkg::t_job     o_job,
    input  wire logic          i_job_ready
);
    import sngh_pkg::*;

    localparam int KW = (MAX_NGRAM_LEN > 1) ? $clog2(MAX_NGRAM_LEN) : 1;
    localparam logic [KW-1:0] K_TOP = KW'(MAX_NGRAM_LEN - 1);
    localparam logic [4:0] MAX_LEN = 5'(MAX_NGRAM_LEN);

    typedef enum logic [7:0] {
        FS_IDLE   = 8'b0000_0001,
        FS_MAIN   = 8'b0000_0010,
        FS_MSHIFT = 8'b0000_0100,
        FS_C1     = 8'b0000_1000,
        FS_C1SH   = 8'b0001_0000,
        FS_C2     = 8'b0010_0000,
        FS_END    = 8'b0100_0000,
        FS_FLUSH  = 8'b1000_0000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [KW-1:0] r_k;
    logic        r_hv [MAX_NGRAM_LEN];
    logic [31:0] r_hh [MAX_NGRAM_LEN];
    logic [7:0]  r_byte;
    logic        r_cont, r_eot, r_close, r_in_word, r_pend;
    logic        r_held_v;
    t_job        r_held;

    logic [4:0]  emax, k1;
    logic        head_v, pass, scan_en, skip, qual, step_ok, adv, pass_end;
    logic [31:0] head_h, xh;
    logic        xv;
    logic [7:0]  fb;
    logic        new_job_v;
    t_job        new_job;
    logic        acc, sp, cnt_byte;
    t_fstate     after_main;

    always_comb begin
        emax = ({1'b0, i_cfg.max_ngram} > MAX_LEN) ? MAX_LEN : {1'b0, i_cfg.max_ngram};
        k1 = 5'(r_k) + 5'd1;
        head_v = r_hv[MAX_NGRAM_LEN-1];
        head_h = r_hh[MAX_NGRAM_LEN-1];
        pass = (r_state == FS_MAIN) || (r_state == FS_C1) || (r_state == FS_C2);
        scan_en = ((r_state == FS_MAIN) && !r_cont) || (r_state == FS_C1) ||
                  (r_state == FS_C2);
        skip = (r_state == FS_C2) ? 1'b1 : r_pend;
        qual = scan_en && head_v && (k1 >= {1'b0, i_cfg.min_ngram}) && (k1 <= emax) &&
               !((k1 == 5'd1) && skip);
        fb = ((r_state == FS_C1) || (r_state == FS_C1SH)) ? CHAR_CLOSE : r_byte;
        // Pass step: the head slot leaves the ring and its successor value enters.
        if (r_state == FS_C2) begin
            xv = head_v;
            xh = head_h;
        end else if ((r_state == FS_MAIN) && r_cont) begin
            xv = head_v;
            xh = head_v ? fnv_fold(head_h, fb) : head_h;
        end else begin
            xv = head_v && (k1 < emax);
            xh = fnv_fold(head_h, fb);
        end
        new_job_v = (pass && qual) || (r_state == FS_END);
        new_job.hash = head_h;
        new_job.kind = (r_state == FS_END);
        new_job.last = 1'b0;
        step_ok = !new_job_v || !r_held_v || i_job_ready;
        adv = pass && step_ok;
        pass_end = adv && (r_k == '0);
        o_job_valid = r_held_v && (new_job_v || (r_state == FS_FLUSH));
        o_job = r_held;
        o_job.last = (r_state == FS_FLUSH);
        acc = (r_state == FS_IDLE) && i_in_valid;
        sp = is_space(i_text_byte);
        cnt_byte = (i_text_byte & CONT_MASK) == CONT_CODE;
        o_in_stall = (r_state != FS_IDLE);
        after_main = r_close ? FS_C1 : (r_eot ? FS_END : FS_FLUSH);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (i_in_valid) begin
                    if (!sp) n_state = FS_MAIN;
                    else if (r_in_word) n_state = FS_C1;
                    else if (i_end_of_text) n_state = FS_END;
                end
            end
            FS_MAIN:   if (pass_end) n_state = r_cont ? after_main : FS_MSHIFT;
            FS_MSHIFT: n_state = after_main;
            FS_C1:     if (pass_end) n_state = FS_C1SH;
            FS_C1SH:   n_state = FS_C2;
            FS_C2:     if (pass_end) n_state = r_eot ? FS_END : FS_FLUSH;
            FS_END:    if (step_ok) n_state = FS_FLUSH;
            FS_FLUSH:  if (!r_held_v || i_job_ready) n_state = FS_IDLE;
            default:   n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FS_IDLE;
            r_k       <= K_TOP;
            r_in_word <= 1'b0;
            r_pend    <= 1'b0;
            r_held_v  <= 1'b0;
            for (int i = 0; i < MAX_NGRAM_LEN; i++) r_hv[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_byte  <= i_text_byte;
                r_cont  <= cnt_byte;
                r_eot   <= i_end_of_text;
                r_close <= (sp && r_in_word) || (!sp && i_end_of_text);
                r_k     <= K_TOP;
                if (!sp && !r_in_word) begin
                    // A new word opens with the '<' codepoint alone in slot 0.
                    for (int i = 1; i < MAX_NGRAM_LEN; i++) r_hv[i] <= 1'b0;
                    r_hv[0]   <= (emax != 5'd0);
                    r_hh[0]   <= OPEN_HASH;
                    r_pend    <= 1'b1;
                    r_in_word <= 1'b1;
                end
            end
            if (adv) begin
                r_k <= pass_end ? K_TOP : r_k - KW'(1);
                if (pass_end && (r_state == FS_C2)) begin
                    for (int i = 0; i < MAX_NGRAM_LEN; i++) r_hv[i] <= 1'b0;
                    r_in_word <= 1'b0;
                    r_pend    <= 1'b0;
                end else begin
                    for (int i = MAX_NGRAM_LEN - 1; i > 0; i--) begin
                        r_hv[i] <= r_hv[i-1];
                        r_hh[i] <= r_hh[i-1];
                    end
                    r_hv[0] <= xv;
                    r_hh[0] <= xh;
                end
            end
            if ((r_state == FS_MSHIFT) || (r_state == FS_C1SH)) begin
                // Every slot moves up one place and slot 0 starts the new codepoint.
                for (int i = MAX_NGRAM_LEN - 1; i > 0; i--) begin
                    r_hv[i] <= r_hv[i-1];
                    r_hh[i] <= r_hh[i-1];
                end
                r_hv[0] <= (emax != 5'd0);
                r_hh[0] <= fnv_fold(FNV_BASIS, fb);
                if (r_state == FS_MSHIFT) r_pend <= 1'b0;
            end
            if (new_job_v && step_ok) begin
                r_held_v <= 1'b1;
                r_held   <= new_job;
            end else if ((r_state == FS_FLUSH) && i_job_ready) begin
                r_held_v <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sngh_fifo.sv
// Short job queue between the front end and the modulo back end.
`default_nettype none
module sngh_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sngh_pkg::t_job i_data,
    output logic               o_ready,
    output logic               o_valid,
    output sngh_pkg::t_job     o_data,
    input  wire logic          i_pop
);
    import sngh_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;
    logic          do_push, do_pop;

    always_comb begin
        o_ready = (r_count != (PW+1)'(DEPTH));
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rd];
        do_push = i_push && o_ready;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + PW'(1);
            if (do_pop)  r_rd <= r_rd + PW'(1);
            if (do_push && !do_pop) r_count <= r_count + (PW+1)'(1);
            else if (!do_push && do_pop) r_count <= r_count - (PW+1)'(1);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sngh_back.sv
// Back end: reduces each n-gram hash modulo the bucket count, offsets it by the word count and presents the row.
`default_nettype none
module sngh_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire sngh_pkg::t_job i_job,
    output logic               o_job_pop,
    input  wire sngh_pkg::t_cfg i_cfg,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [31:0]        o_row_index,
    output logic               o_row_kind,
    output logic               o_last
);
    import sngh_pkg::*;

    typedef enum logic [3:0] {
        BS_IDLE = 4'b0001,
        BS_DIV  = 4'b0010,
        BS_SUM  = 4'b0100,
        BS_OUT  = 4'b1000
    } t_bstate;

    t_bstate     r_state;
    logic [31:0] r_num, r_rem, r_row;
    logic [4:0]  r_cnt;
    logic        r_kind, r_last;
    logic [31:0] trial;

    always_comb begin
        o_job_pop = (r_state == BS_IDLE) && i_job_valid;
        o_out_valid = (r_state == BS_OUT);
        o_row_index = r_row;
        o_row_kind  = r_kind;
        o_last      = r_last;
        // Restoring division, one quotient bit a cycle; the remainder stays below 2^31.
        trial = {r_rem[30:0], r_num[31]};
        if (trial >= {1'b0, i_cfg.bucket_count}) trial = trial - {1'b0, i_cfg.bucket_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            unique case (r_state)
                BS_IDLE: begin
                    if (i_job_valid) begin
                        r_kind <= i_job.kind;
                        r_last <= i_job.last;
                        r_num  <= i_job.hash;
                        r_rem  <= '0;
                        r_cnt  <= 5'd31;
                        if (i_job.kind) begin
                            r_row   <= EOS_ROW;
                            r_state <= BS_OUT;
                        end else if (i_cfg.bucket_count == '0) begin
                            r_state <= BS_SUM;
                        end else begin
                            r_state <= BS_DIV;
                        end
                    end
                end
                BS_DIV: begin
                    r_rem <= trial;
                    r_num <= {r_num[30:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) r_state <= BS_SUM;
                end
                BS_SUM: begin
                    r_row   <= {8'd0, i_cfg.word_count} + r_rem;
                    r_state <= BS_OUT;
                end
                BS_OUT: if (!i_out_stall) r_state <= BS_IDLE;
                default: r_state <= BS_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/subword_ngram_hasher.sv
// Input: a byte is taken while the front end is idle, then the input stalls through the slot ring
// pass, the shift and the flush (no shift for a continuation byte); closing a word adds a pass,
// a shift and a second pass, an end row one more state, and a full job queue holds the pass.
// Each n-gram row then goes through the bit-serial divider (skipped with a zero bucket count),
// an end row goes straight to the output, and any output stall holds a row; throughput is set by rows.
// Synchronous active-low reset clears the slots, word state, queue and registers.
`default_nettype none
module subword_ngram_hasher #(
    parameter int MAX_NGRAM_LEN = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_row_index,
    output logic             o_row_kind,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import sngh_pkg::*;

    t_cfg r_cfg;
    logic f_valid, f_ready, q_valid, q_pop;
    t_job f_job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_ngram    <= 4'd3;
            r_cfg.max_ngram    <= 4'd6;
            r_cfg.bucket_count <= 31'd2000000;
            r_cfg.word_count   <= 24'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_NGRAM:    r_cfg.min_ngram    <= i_cfg_data[3:0];
                CFG_MAX_NGRAM:    r_cfg.max_ngram    <= i_cfg_data[3:0];
                CFG_BUCKET_COUNT: r_cfg.bucket_count <= i_cfg_data[30:0];
                CFG_WORD_COUNT:   r_cfg.word_count   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    sngh_front #(.MAX_NGRAM_LEN(MAX_NGRAM_LEN)) u_front (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_stall, .i_text_byte, .i_end_of_text,
        .i_cfg(r_cfg),
        .o_job_valid(f_valid), .o_job(f_job), .i_job_ready(f_ready)
    );

    sngh_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(f_valid), .i_data(f_job), .o_ready(f_ready),
        .o_valid(q_valid), .o_data(q_job), .i_pop(q_pop)
    );

    sngh_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(q_valid), .i_job(q_job), .o_job_pop(q_pop),
        .i_cfg(r_cfg),
        .o_out_valid, .i_out_stall, .o_row_index, .o_row_kind, .o_last
    );

endmodule
`default_nettype wire

// File: sim/tb_subword_ngram_hasher.sv
// Self-checking testbench for the subword n-gram hasher: predicts every row and checks it.
`default_nettype none

class row_scoreboard;
    // Predictor copy of the configuration.
    logic [3:0]  min_len;
    logic [3:0]  max_len;
    logic [30:0] buckets;
    logic [23:0] vocab;
    // Predictor copy of the n-gram slots.
    logic [31:0] slot_hash [8];
    logic [3:0]  slot_len [8];
    logic        slot_on [8];
    logic        word_open;
    logic        open_mark_pending;
    // Expected rows, oldest first.
    logic [31:0] exp_row [$];
    logic        exp_kind [$];
    logic        exp_last [$];
    int          mismatches;
    int          rows_checked;

    function new();
        mismatches = 0;
        rows_checked = 0;
        reset_state();
    endfunction

    function void reset_state();
        min_len = 4'd3;
        max_len = 4'd6;
        buckets = 31'd2000000;
        vocab = 24'd0;
        clear_slots();
        word_open = 1'b0;
        open_mark_pending = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            sngh_pkg::CFG_MIN_NGRAM:    min_len = value[3:0];
            sngh_pkg::CFG_MAX_NGRAM:    max_len = value[3:0];
            sngh_pkg::CFG_BUCKET_COUNT: buckets = value[30:0];
            sngh_pkg::CFG_WORD_COUNT:   vocab = value[23:0];
            default: ;
        endcase
    endfunction

    function void clear_slots();
        for (int k = 0; k < 8; k++) begin
            slot_hash[k] = '0;
            slot_len[k] = '0;
            slot_on[k] = 1'b0;
        end
    endfunction

    function logic [31:0] hash_byte(logic [31:0] h, logic [7:0] b);
        logic [31:0] x;
        x = h ^ {{24{b[7]}}, b};
        return x * 32'd16777619;
    endfunction

    function logic [3:0] top_len();
        return (max_len > 4'd8) ? 4'd8 : max_len;
    endfunction

    function void push_row(logic [31:0] row, logic kind);
        exp_row = {exp_row, row};
        exp_kind = {exp_kind, kind};
        exp_last = {exp_last, 1'b0};
    endfunction

    // Rows for every n-gram ending at the codepoint just finished, longest first.
    function void finish_codepoint(logic skip_single);
        logic [3:0]  emax;
        logic [31:0] rem;
        emax = top_len();
        for (int k = 7; k >= 0; k--) begin
            if (slot_on[k] && slot_len[k] >= min_len && slot_len[k] <= emax &&
                !(slot_len[k] == 4'd1 && skip_single)) begin
                rem = (buckets == 0) ? 32'd0 : slot_hash[k] % {1'b0, buckets};
                push_row({8'd0, vocab} + rem, 1'b0);
            end
        end
    endfunction

    function void begin_codepoint(logic [7:0] b);
        logic [3:0] emax;
        emax = top_len();
        open_mark_pending = 1'b0;
        for (int k = 7; k >= 1; k--) begin
            if (k < emax && slot_on[k-1]) begin
                slot_hash[k] = hash_byte(slot_hash[k-1], b);
                slot_len[k] = slot_len[k-1] + 4'd1;
                slot_on[k] = 1'b1;
            end else begin
                slot_hash[k] = '0;
                slot_len[k] = '0;
                slot_on[k] = 1'b0;
            end
        end
        slot_on[0] = (emax >= 1);
        slot_hash[0] = slot_on[0] ? hash_byte(sngh_pkg::FNV_BASIS, b) : '0;
        slot_len[0] = slot_on[0] ? 4'd1 : 4'd0;
    endfunction

    function void close_current_word();
        finish_codepoint(open_mark_pending);
        begin_codepoint(sngh_pkg::CHAR_CLOSE);
        finish_codepoint(1'b1);
        clear_slots();
        word_open = 1'b0;
        open_mark_pending = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B ||
               b == 8'h0C || b == 8'h0D || b == 8'h00;
    endfunction

    // Note an accepted input transfer and queue the rows it causes.
    function void note_byte(logic [7:0] b, logic eot);
        int before_count;
        before_count = exp_row.size();
        if (is_blank(b)) begin
            if (word_open) close_current_word();
        end else begin
            if (!word_open) begin
                clear_slots();
                word_open = 1'b1;
                begin_codepoint(sngh_pkg::CHAR_OPEN);
                open_mark_pending = 1'b1;
            end
            if ((b & sngh_pkg::CONT_MASK) == sngh_pkg::CONT_CODE) begin
                for (int k = 0; k < 8; k++)
                    if (slot_on[k]) slot_hash[k] = hash_byte(slot_hash[k], b);
            end else begin
                finish_codepoint(open_mark_pending);
                begin_codepoint(b);
            end
        end
        if (eot) begin
            if (word_open) close_current_word();
            push_row(sngh_pkg::EOS_ROW, 1'b1);
        end
        if (exp_row.size() > before_count) exp_last[exp_last.size()-1] = 1'b1;
    endfunction

    // Check one accepted output transfer against the oldest expected row.
    function void check_row(logic [31:0] row, logic kind, logic lst);
        logic [31:0] er;
        logic ek;
        logic el;
        rows_checked++;
        if (exp_row.size() == 0) begin
            $display("%0t: unexpected row: row_index %0d kind %0d last %0d",
                     $time, row, kind, lst);
            mismatches++;
            return;
        end
        er = exp_row.pop_front();
        ek = exp_kind.pop_front();
        el = exp_last.pop_front();
        if (row !== er) begin
            $display("%0t: row_index expected %0d actual %0d", $time, er, row);
            mismatches++;
        end
        if (kind !== ek) begin
            $display("%0t: row_kind expected %0d actual %0d", $time, ek, kind);
            mismatches++;
        end
        if (lst !== el) begin
            $display("%0t: last expected %0d actual %0d", $time, el, lst);
            mismatches++;
        end
    endfunction
endclass

module tb_subword_ngram_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] row_index;
    logic        row_kind;
    logic        row_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  idle_cycles;
    int  bytes_sent;
    bit  timed_out;

    row_scoreboard rows;

    subword_ngram_hasher dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_text_byte(text_byte), .i_end_of_text(end_of_text),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_row_index(row_index), .o_row_kind(row_kind), .o_last(row_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Receiver: stall at random, or for a long stretch when asked.
    always @(negedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            rows.check_row(row_index, row_kind, row_last);
    end

    // Watchdog: counts cycles in which no transfer happens on any channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired", $time);
            $display("tb_subword_ngram_hasher: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid = 1'b1;
        text_byte <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        rows.note_byte(b, eot);
        bytes_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        rows.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every expected row has arrived, then let the block drain.
    task automatic wait_drained();
        while (rows.exp_row.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic set_cfg(input logic [3:0] mn, input logic [3:0] mx,
                           input logic [30:0] bc, input logic [23:0] wc);
        wait_drained();
        write_cfg(sngh_pkg::CFG_MIN_NGRAM, {28'd0, mn});
        write_cfg(sngh_pkg::CFG_MAX_NGRAM, {28'd0, mx});
        write_cfg(sngh_pkg::CFG_BUCKET_COUNT, {1'b0, bc});
        write_cfg(sngh_pkg::CFG_WORD_COUNT, {8'd0, wc});
    endtask

    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) return 8'h20;
        if (pick < 50) return 8'h61 + 8'($urandom_range(25));
        if (pick < 65) return 8'h80 | 8'($urandom_range(63));
        if (pick < 75) return 8'hC0 | 8'($urandom_range(63));
        if (pick < 80) return sngh_pkg::CHAR_OPEN;
        return 8'($urandom_range(255));
    endfunction

    // Words of plain and multi-byte letters, with the odd stray byte.
    task automatic random_text(input int count);
        int n;
        n = 0;
        while (n < count) begin
            send_byte(random_text_byte(), ($urandom_range(39) == 0));
            n++;
        end
    endtask

    initial begin
        rows = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_byte = 8'd0;
        end_of_text = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sngh_pkg::CFG_MIN_NGRAM;
        cfg_data = 32'd0;
        send_idle_pct = 10;
        recv_stall_pct = 54;
        hold_off = 1'b0;
        bytes_sent = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, ASCII and multi-byte words, blanks, end of text.
        send_byte("h", 0); send_byte("e", 0); send_byte("l", 0); send_byte("l", 0);
        send_byte("o", 0); send_byte(8'h09, 0);
        send_byte(8'hC3, 0); send_byte(8'hA9, 0); send_byte("t", 0);
        send_byte(8'hE2, 0); send_byte(8'h82, 0); send_byte(8'hAC, 0);
        send_byte(8'h0A, 0);
        send_byte(8'hBF, 0); send_byte("a", 0); send_byte(8'h00, 1);
        send_byte(8'h20, 1);
        send_byte(8'hFF, 0); send_byte(8'h7F, 1);
        send_byte(8'h0B, 0); send_byte(8'h0C, 0); send_byte(8'h0D, 0);

        // Edge settings: zero buckets and largest offset, single codepoints, min above max, max of zero.
        set_cfg(4'd0, 4'd15, 31'd0, 24'hFFFFFF);
        send_byte("x", 0); send_byte(8'h80, 0); send_byte("y", 1);
        set_cfg(4'd1, 4'd1, 31'h7FFFFFFF, 24'd0);
        send_byte("a", 0); send_byte("b", 1);
        set_cfg(4'd5, 4'd2, 31'd1, 24'd7);
        send_byte("q", 0); send_byte("r", 1);
        set_cfg(4'd15, 4'd0, 31'd3, 24'd1);
        send_byte("z", 1);

        set_cfg(4'd3, 4'd6, 31'd2000000, 24'd1000);
        random_text(110);

        // Long receiver hold-off, timed on its own, while the sender keeps offering bytes.
        fork
            random_text(40);
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
        join

        set_cfg(4'd1, 4'd8, 31'h7FFFFFFF, 24'hFFFFFF);
        random_text(110);
        send_idle_pct = 54;
        recv_stall_pct = 10;
        set_cfg(4'd2, 4'd4, 31'd97, 24'd12345);
        random_text(110);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_cfg(4'd1, 4'd12, 31'd65536, 24'd0);
        random_text(70);
        send_byte(8'h20, 1);

        wait_drained();
        $display("Sent %0d text bytes over several n-gram settings; checked %0d rows.",
                 bytes_sent, rows.rows_checked);
        if (rows.mismatches == 0 && rows.exp_row.size() == 0)
            $display("tb_subword_ngram_hasher: clean");
        else
            $display("tb_subword_ngram_hasher: errors");
        $finish;
    end
endmodule
`default_nettype wire
